// File: hw/rtl/bsls_pkg.sv
package bsls_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_FAULT_BLINK   = 3'd0;
  localparam logic [2:0] REG_CHARGE_BLINK  = 3'd1;
  localparam logic [2:0] REG_HB_OFF        = 3'd2;
  localparam logic [2:0] REG_HB_ON         = 3'd3;
  localparam logic [2:0] REG_BAL_BLINK     = 3'd4;
  localparam logic [2:0] REG_BAL_SPREAD    = 3'd5;
  localparam logic [2:0] REG_BAL_PACK      = 3'd6;
  localparam logic [2:0] REG_MIN_CEILING   = 3'd7;

  // register reset values
  localparam logic [15:0] RST_FAULT_BLINK  = 16'd100;
  localparam logic [15:0] RST_CHARGE_BLINK = 16'd500;
  localparam logic [15:0] RST_HB_OFF       = 16'd2900;
  localparam logic [15:0] RST_HB_ON        = 16'd100;
  localparam logic [15:0] RST_BAL_BLINK    = 16'd250;
  localparam logic [15:0] RST_BAL_SPREAD   = 16'd100;
  localparam logic [16:0] RST_BAL_PACK     = 17'd45000;
  localparam logic [15:0] RST_MIN_CEILING  = 16'd5000;

  // system states
  localparam logic [1:0] SYS_CHARGING = 2'd2;
  localparam logic [1:0] SYS_FAULT    = 2'd3;

  // item functions
  localparam logic FUNC_CELL_WRITE = 1'b0;
  localparam logic FUNC_UPDATE     = 1'b1;

  // sequencer states
  localparam logic [3:0] ST_IDLE       = 4'd0;
  localparam logic [3:0] ST_SYS_DIFF   = 4'd1;
  localparam logic [3:0] ST_SYS_CMP    = 4'd2;
  localparam logic [3:0] ST_SCAN       = 4'd3;
  localparam logic [3:0] ST_SPREAD     = 4'd4;
  localparam logic [3:0] ST_BAL_SPREAD = 4'd5;
  localparam logic [3:0] ST_BAL_PACK   = 4'd6;
  localparam logic [3:0] ST_BAL_DIFF   = 4'd7;
  localparam logic [3:0] ST_BAL_CMP    = 4'd8;
  localparam logic [3:0] ST_DONE       = 4'd9;

  typedef logic [32:0] alu_res_t;

endpackage

// File: hw/rtl/battery_status_led_sequencer.sv
// timing: a cell-write transaction is stored at its accept edge and gives no result; an
//   update result is registered in ST_DONE after the time, scan (skipped with pack voltage
//   0) and balance states, waiting there while a stalled previous result holds it back
// throughput: cell writes back to back while idle; no new item is taken until an update is
//   done, the single shared 33-bit subtractor doing every time, scan and threshold test
// reset: synchronous active-high rst restores register defaults, clears cells, stamps and led levels
module battery_status_led_sequencer import bsls_pkg::*; #(
  parameter int NUM_CELLS = 15
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_addr,
  input  logic [16:0] cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [3:0]  cell_index,
  input  logic [15:0] cell_voltage,
  input  logic [31:0] now_ms,
  input  logic [1:0]  system_state,
  input  logic [16:0] total_voltage,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        sys_led,
  output logic        bal_led,
  output logic        balancing,
  output logic [15:0] cell_spread
);

  localparam int CW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam logic [5:0] NCELLS = 6'(NUM_CELLS);
  localparam logic [CW-1:0] LAST_CELL = CW'(NUM_CELLS - 1);

  // configuration registers
  logic [15:0] fault_blink_ms;
  logic [15:0] charge_blink_ms;
  logic [15:0] heartbeat_off_ms;
  logic [15:0] heartbeat_on_ms;
  logic [15:0] balance_blink_ms;
  logic [15:0] balance_spread_mv;
  logic [16:0] balance_pack_mv;
  logic [15:0] min_ceiling_mv;

  // persistent led state
  logic [15:0] cell_store [NUM_CELLS];
  logic [31:0] sys_led_stamp;
  logic [31:0] bal_led_stamp;
  logic        heartbeat_lit;
  logic        sys_led_level;
  logic        bal_led_level;

  // working registers of one update
  logic [3:0]    state;
  logic [31:0]   now_q;
  logic [1:0]    sys_state_q;
  logic [16:0]   total_q;
  logic [31:0]   delta;
  logic [15:0]   vmax;
  logic [15:0]   vmin;
  logic [15:0]   spread;
  logic          spread_ok;
  logic          bal_flag;
  logic [CW-1:0] cnt;
  logic          phase;  // 0 max test, 1 min test

  // shared subtractor: res = a - b, bit 32 is the borrow (a < b)
  logic [31:0] alu_a;
  logic [31:0] alu_b;
  alu_res_t    alu_res;
  logic        alu_lt;
  logic [15:0] cur_cell;
  logic [15:0] sys_period;
  logic        in_accept;
  logic        out_free;

  assign alu_res   = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_lt    = alu_res[32];
  assign cur_cell  = cell_store[cnt];
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // period for the system led, chosen by mode and heartbeat phase
  always_comb begin
    if (sys_state_q == SYS_FAULT) begin
      sys_period = fault_blink_ms;
    end else if (sys_state_q == SYS_CHARGING) begin
      sys_period = charge_blink_ms;
    end else if (!heartbeat_lit) begin
      sys_period = heartbeat_off_ms;
    end else begin
      sys_period = heartbeat_on_ms;
    end
  end

  // operand select for the shared unit
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (state)
      ST_SYS_DIFF: begin
        alu_a = now_q;
        alu_b = sys_led_stamp;
      end
      ST_SYS_CMP: begin
        alu_a = delta;
        alu_b = {16'd0, sys_period};
      end
      ST_SCAN: begin
        if (!phase) begin
          alu_a = {16'd0, vmax};
          alu_b = {16'd0, cur_cell};
        end else begin
          alu_a = {16'd0, cur_cell};
          alu_b = {16'd0, vmin};
        end
      end
      ST_SPREAD: begin
        alu_a = {16'd0, vmax};
        alu_b = {16'd0, vmin};
      end
      ST_BAL_SPREAD: begin
        alu_a = {16'd0, spread};
        alu_b = {16'd0, balance_spread_mv};
      end
      ST_BAL_PACK: begin
        // total > threshold is threshold - total borrowing
        alu_a = {15'd0, balance_pack_mv};
        alu_b = {15'd0, total_q};
      end
      ST_BAL_DIFF: begin
        alu_a = now_q;
        alu_b = bal_led_stamp;
      end
      ST_BAL_CMP: begin
        alu_a = delta;
        alu_b = {16'd0, balance_blink_ms};
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fault_blink_ms    <= RST_FAULT_BLINK;
      charge_blink_ms   <= RST_CHARGE_BLINK;
      heartbeat_off_ms  <= RST_HB_OFF;
      heartbeat_on_ms   <= RST_HB_ON;
      balance_blink_ms  <= RST_BAL_BLINK;
      balance_spread_mv <= RST_BAL_SPREAD;
      balance_pack_mv   <= RST_BAL_PACK;
      min_ceiling_mv    <= RST_MIN_CEILING;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        REG_FAULT_BLINK:  fault_blink_ms    <= cfg_wdata[15:0];
        REG_CHARGE_BLINK: charge_blink_ms   <= cfg_wdata[15:0];
        REG_HB_OFF:       heartbeat_off_ms  <= cfg_wdata[15:0];
        REG_HB_ON:        heartbeat_on_ms   <= cfg_wdata[15:0];
        REG_BAL_BLINK:    balance_blink_ms  <= cfg_wdata[15:0];
        REG_BAL_SPREAD:   balance_spread_mv <= cfg_wdata[15:0];
        REG_BAL_PACK:     balance_pack_mv   <= cfg_wdata;
        REG_MIN_CEILING:  min_ceiling_mv    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // cell store: written straight from the input channel, out of range index dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CELLS; i++) begin
        cell_store[i] <= '0;
      end
    end else if (in_accept && func == FUNC_CELL_WRITE && {2'b00, cell_index} < NCELLS) begin
      cell_store[CW'(cell_index)] <= cell_voltage;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      sys_led_stamp <= '0;
      bal_led_stamp <= '0;
      heartbeat_lit <= 1'b0;
      sys_led_level <= 1'b0;
      bal_led_level <= 1'b0;
      out_valid     <= 1'b0;
      cnt           <= '0;
      phase         <= 1'b0;
    end else begin
      // a taken result drops valid unless a new one is loaded this cycle
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept && func == FUNC_UPDATE) begin
            now_q       <= now_ms;
            sys_state_q <= system_state;
            total_q     <= total_voltage;
            state       <= ST_SYS_DIFF;
          end
        end
        ST_SYS_DIFF: begin
          delta <= alu_res[31:0];
          state <= ST_SYS_CMP;
        end
        ST_SYS_CMP: begin
          if (!alu_lt) begin
            sys_led_stamp <= now_q;
            if (sys_state_q == SYS_FAULT || sys_state_q == SYS_CHARGING) begin
              sys_led_level <= !sys_led_level;
            end else begin
              // heartbeat flips between lit and dark phase
              sys_led_level <= !heartbeat_lit;
              heartbeat_lit <= !heartbeat_lit;
            end
          end
          vmax  <= '0;
          vmin  <= min_ceiling_mv;
          cnt   <= '0;
          phase <= 1'b0;
          // unknown pack voltage skips the scan
          state <= (total_q != '0) ? ST_SCAN : ST_SPREAD;
        end
        ST_SCAN: begin
          if (!phase) begin
            if (alu_lt) begin
              vmax <= cur_cell;
            end
            phase <= 1'b1;
          end else begin
            if (alu_lt) begin
              vmin <= cur_cell;
            end
            phase <= 1'b0;
            if (cnt == LAST_CELL) begin
              state <= ST_SPREAD;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        ST_SPREAD: begin
          spread <= alu_res[15:0];
          state  <= ST_BAL_SPREAD;
        end
        ST_BAL_SPREAD: begin
          spread_ok <= !alu_lt;
          state     <= ST_BAL_PACK;
        end
        ST_BAL_PACK: begin
          if (spread_ok && alu_lt) begin
            bal_flag <= 1'b1;
            state    <= ST_BAL_DIFF;
          end else begin
            // no balancing: led forced dark, stamp kept
            bal_flag      <= 1'b0;
            bal_led_level <= 1'b0;
            state         <= ST_DONE;
          end
        end
        ST_BAL_DIFF: begin
          delta <= alu_res[31:0];
          state <= ST_BAL_CMP;
        end
        ST_BAL_CMP: begin
          if (!alu_lt) begin
            bal_led_level <= !bal_led_level;
            bal_led_stamp <= now_q;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          // wait here while the previous result is still held
          if (out_free) begin
            out_valid   <= 1'b1;
            sys_led     <= sys_led_level;
            bal_led     <= bal_led_level;
            balancing   <= bal_flag;
            cell_spread <= spread;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: test/led_report_checker.sv
`timescale 1ns / 1ps

module led_report_checker import bsls_pkg::*; #(
  parameter int NUM_CELLS = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_addr,
  input  logic [16:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        func,
  input  logic [3:0]  cell_index,
  input  logic [15:0] cell_voltage,
  input  logic [31:0] now_ms,
  input  logic [1:0]  system_state,
  input  logic [16:0] total_voltage,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        sys_led,
  input  logic        bal_led,
  input  logic        balancing,
  input  logic [15:0] cell_spread,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic        sys_led;
    logic        bal_led;
    logic        balancing;
    logic [15:0] spread;
  } led_report_t;

  // shadow of the register file
  logic [15:0] fault_ms, charge_ms, hb_off_ms, hb_on_ms, bal_ms, spread_mv, ceiling_mv;
  logic [16:0] pack_mv;

  // shadow of the block state
  logic [15:0] cells [NUM_CELLS];
  logic [31:0] sys_stamp, bal_stamp;
  logic        hb_lit, sys_level, bal_level;

  led_report_t reports_due[$];
  int          mismatches;

  // wrapping elapsed-time test
  function automatic logic ripe(logic [31:0] now, logic [31:0] stamp, logic [15:0] period);
    logic [31:0] gap;
    gap = now - stamp;
    return gap >= {16'd0, period};
  endfunction

  task automatic predict_update(input logic [31:0] now, input logic [1:0] st,
                                input logic [16:0] total, output led_report_t rep);
    logic [15:0] vmax, vmin;
    logic        bal;
    if (st == SYS_FAULT || st == SYS_CHARGING) begin
      if (ripe(now, sys_stamp, (st == SYS_FAULT) ? fault_ms : charge_ms)) begin
        sys_level = ~sys_level;
        sys_stamp = now;
      end
    end else if (!hb_lit) begin
      if (ripe(now, sys_stamp, hb_off_ms)) begin
        sys_level = 1'b1;
        hb_lit    = 1'b1;
        sys_stamp = now;
      end
    end else if (ripe(now, sys_stamp, hb_on_ms)) begin
      sys_level = 1'b0;
      hb_lit    = 1'b0;
      sys_stamp = now;
    end

    vmax = 16'd0;
    vmin = ceiling_mv;
    if (total != 17'd0) begin
      for (int i = 0; i < NUM_CELLS; i++) begin
        if (cells[i] > vmax) vmax = cells[i];
        if (cells[i] < vmin) vmin = cells[i];
      end
    end
    rep.spread = vmax - vmin;

    bal = ({1'b0, rep.spread} >= {1'b0, spread_mv}) && (total > pack_mv);
    if (bal) begin
      if (ripe(now, bal_stamp, bal_ms)) begin
        bal_level = ~bal_level;
        bal_stamp = now;
      end
    end else begin
      bal_level = 1'b0;
    end

    rep.sys_led   = sys_level;
    rep.bal_led   = bal_level;
    rep.balancing = bal;
  endtask

  always @(posedge clk) begin : watch
    led_report_t due;
    if (rst) begin
      fault_ms   = RST_FAULT_BLINK;
      charge_ms  = RST_CHARGE_BLINK;
      hb_off_ms  = RST_HB_OFF;
      hb_on_ms   = RST_HB_ON;
      bal_ms     = RST_BAL_BLINK;
      spread_mv  = RST_BAL_SPREAD;
      pack_mv    = RST_BAL_PACK;
      ceiling_mv = RST_MIN_CEILING;
      for (int i = 0; i < NUM_CELLS; i++) cells[i] = 16'd0;
      sys_stamp  = 32'd0;
      bal_stamp  = 32'd0;
      hb_lit     = 1'b0;
      sys_level  = 1'b0;
      bal_level  = 1'b0;
      mismatches = 0;
      reports_due.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_addr)
          REG_FAULT_BLINK:  fault_ms   = cfg_wdata[15:0];
          REG_CHARGE_BLINK: charge_ms  = cfg_wdata[15:0];
          REG_HB_OFF:       hb_off_ms  = cfg_wdata[15:0];
          REG_HB_ON:        hb_on_ms   = cfg_wdata[15:0];
          REG_BAL_BLINK:    bal_ms     = cfg_wdata[15:0];
          REG_BAL_SPREAD:   spread_mv  = cfg_wdata[15:0];
          REG_BAL_PACK:     pack_mv    = cfg_wdata;
          REG_MIN_CEILING:  ceiling_mv = cfg_wdata[15:0];
          default: ;
        endcase
      end

      // results leave before the same-edge input is predicted
      if (out_valid && !out_stall) begin
        if (reports_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected led report, expected none, actual %0b %0b %0b %0d",
                   $time, sys_led, bal_led, balancing, cell_spread);
        end else begin
          due = reports_due.pop_front();
          if (sys_led !== due.sys_led) begin
            mismatches++;
            $display("%0t: sys_led expected %0b actual %0b", $time, due.sys_led, sys_led);
          end
          if (bal_led !== due.bal_led) begin
            mismatches++;
            $display("%0t: bal_led expected %0b actual %0b", $time, due.bal_led, bal_led);
          end
          if (balancing !== due.balancing) begin
            mismatches++;
            $display("%0t: balancing expected %0b actual %0b", $time, due.balancing,
                     balancing);
          end
          if (cell_spread !== due.spread) begin
            mismatches++;
            $display("%0t: cell_spread expected %0d actual %0d", $time, due.spread,
                     cell_spread);
          end
        end
      end

      if (in_valid && !in_stall) begin
        if (func == FUNC_CELL_WRITE) begin
          if (cell_index < NUM_CELLS) cells[cell_index] = cell_voltage;
        end else begin
          predict_update(now_ms, system_state, total_voltage, due);
          reports_due.push_back(due);
        end
      end
    end
    errors  <= mismatches;
    pending <= reports_due.size();
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top import bsls_pkg::*;;

  // system states the package leaves unnamed
  localparam logic [1:0] SYS_IDLE      = 2'd0;
  localparam logic [1:0] SYS_DISCHARGE = 2'd1;

  // worst update latency plus a little margin
  localparam int DRAIN_CYCLES = 2 * 15 + 8 + 2;

  logic        clk;
  logic        rst           = 1'b1;
  logic        cfg_wen       = 1'b0;
  logic [2:0]  cfg_addr      = REG_FAULT_BLINK;
  logic [16:0] cfg_wdata     = 17'd0;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic        func          = FUNC_CELL_WRITE;
  logic [3:0]  cell_index    = 4'd0;
  logic [15:0] cell_voltage  = 16'd0;
  logic [31:0] now_ms        = 32'd0;
  logic [1:0]  system_state  = SYS_IDLE;
  logic [16:0] total_voltage = 17'd0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic        sys_led;
  logic        bal_led;
  logic        balancing;
  logic [15:0] cell_spread;

  int          errors;
  int          pending;

  // stimulus-side knobs
  logic        calm;          // no idling on either side while set
  logic [31:0] clock_ms;      // running millisecond tick for update transactions
  logic [1:0]  plant_state;   // system state, mostly held across updates

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  battery_status_led_sequencer dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .cell_index    (cell_index),
    .cell_voltage  (cell_voltage),
    .now_ms        (now_ms),
    .system_state  (system_state),
    .total_voltage (total_voltage),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sys_led       (sys_led),
    .bal_led       (bal_led),
    .balancing     (balancing),
    .cell_spread   (cell_spread)
  );

  led_report_checker #(.NUM_CELLS(15)) watch (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .cell_index    (cell_index),
    .cell_voltage  (cell_voltage),
    .now_ms        (now_ms),
    .system_state  (system_state),
    .total_voltage (total_voltage),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sys_led       (sys_led),
    .bal_led       (bal_led),
    .balancing     (balancing),
    .cell_spread   (cell_spread),
    .errors        (errors),
    .pending       (pending)
  );

  // receiver back-pressure: stall about a third of the cycles
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 34);
    end
  end

  // one input transaction: optional idle gap, then hold until accepted
  task automatic send(input logic f, input logic [3:0] idx, input logic [15:0] volt,
                      input logic [31:0] now, input logic [1:0] st, input logic [16:0] tot);
    if (!calm) begin
      while ($urandom_range(99) < 34) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    func          <= f;
    cell_index    <= idx;
    cell_voltage  <= volt;
    now_ms        <= now;
    system_state  <= st;
    total_voltage <= tot;
    do @(posedge clk); while (in_stall);
  endtask

  // wait until every led report has come back and the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [16:0] data);
    cfg_wen   <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // reprogram every register while the block is idle
  task automatic apply_config(input logic [15:0] fault, input logic [15:0] charge,
                              input logic [15:0] hb_off, input logic [15:0] hb_on,
                              input logic [15:0] bal_blink, input logic [15:0] spread,
                              input logic [16:0] pack, input logic [15:0] ceiling);
    settle();
    cfg_write(REG_FAULT_BLINK, {1'b0, fault});
    cfg_write(REG_CHARGE_BLINK, {1'b0, charge});
    cfg_write(REG_HB_OFF, {1'b0, hb_off});
    cfg_write(REG_HB_ON, {1'b0, hb_on});
    cfg_write(REG_BAL_BLINK, {1'b0, bal_blink});
    cfg_write(REG_BAL_SPREAD, {1'b0, spread});
    cfg_write(REG_BAL_PACK, pack);
    cfg_write(REG_MIN_CEILING, {1'b0, ceiling});
    cfg_wen <= 1'b0;
  endtask

  // random mix: cell writes with plausible voltages, updates on a running tick
  task automatic random_items(input int count);
    int          r;
    logic [15:0] volt;
    logic [16:0] tot;
    logic [3:0]  idx;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 45) begin
        r = $urandom_range(99);
        if (r < 70) volt = 16'($urandom_range(4300, 2800));
        else if (r < 85) volt = 16'($urandom);
        else volt = $urandom_range(1) ? 16'hFFFF : 16'($urandom_range(15));
        // an occasional write past the last cell, which the block drops
        idx = ($urandom_range(99) < 8) ? 4'd15 : 4'($urandom_range(14));
        send(FUNC_CELL_WRITE, idx, volt, $urandom, 2'($urandom), 17'($urandom));
      end else begin
        // mostly small steps so the blink timers fire, some long jumps and wraps
        r = $urandom_range(99);
        if (r < 70) clock_ms = clock_ms + $urandom_range(60);
        else if (r < 90) clock_ms = clock_ms + $urandom_range(1000);
        else if (r < 98) clock_ms = clock_ms + $urandom_range(70000);
        else clock_ms = $urandom;
        if ($urandom_range(99) < 12) plant_state = 2'($urandom);
        r = $urandom_range(99);
        if (r < 80) tot = 17'($urandom_range(131071, 30000));
        else if (r < 90) tot = 17'd0;
        else tot = 17'($urandom);
        send(FUNC_UPDATE, 4'($urandom), 16'($urandom), clock_ms, plant_state, tot);
      end
    end
  endtask

  initial begin
    calm        = 1'b0;
    clock_ms    = 32'd0;
    plant_state = SYS_IDLE;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    settle();

    // directed part, register reset values
    // unknown pack voltage: nothing scanned, spread is zero minus the ceiling
    send(FUNC_UPDATE, 4'd0, 16'd0, 32'd0, SYS_IDLE, 17'd0);
    send(FUNC_CELL_WRITE, 4'd0, 16'd0, 32'hFFFF_FFFF, SYS_FAULT, 17'h1FFFF);
    send(FUNC_CELL_WRITE, 4'd14, 16'hFFFF, 32'd0, SYS_IDLE, 17'd0);
    // write past the last cell is dropped
    send(FUNC_CELL_WRITE, 4'd15, 16'h5555, 32'hAAAA_AAAA, SYS_DISCHARGE, 17'h0AAAA);
    send(FUNC_CELL_WRITE, 4'd7, 16'd3700, 32'h5555_5555, SYS_CHARGING, 17'h15555);
    // heartbeat lights once the dark time has run out
    send(FUNC_UPDATE, 4'hF, 16'hFFFF, 32'd2900, SYS_IDLE, 17'h1FFFF);
    // pack equal to the threshold does not count, one above does
    send(FUNC_UPDATE, 4'd0, 16'd0, 32'd2950, SYS_DISCHARGE, 17'd45000);
    send(FUNC_UPDATE, 4'd0, 16'd0, 32'd3000, SYS_DISCHARGE, 17'd45001);
    send(FUNC_UPDATE, 4'd0, 16'd0, 32'd3300, SYS_DISCHARGE, 17'd1);
    // charging and fault blink on the shared stamp, heartbeat phase held
    send(FUNC_UPDATE, 4'd0, 16'd0, 32'd3500, SYS_CHARGING, 17'd60000);
    send(FUNC_UPDATE, 4'd0, 16'd0, 32'd4000, SYS_CHARGING, 17'd60000);
    send(FUNC_UPDATE, 4'd0, 16'd0, 32'd4050, SYS_FAULT, 17'd60000);
    send(FUNC_UPDATE, 4'd0, 16'd0, 32'd4100, SYS_FAULT, 17'd60000);
    send(FUNC_UPDATE, 4'd0, 16'd0, 32'd4250, SYS_FAULT, 17'd60000);
    // heartbeat resumes with its old phase
    send(FUNC_UPDATE, 4'd0, 16'd0, 32'd4300, SYS_IDLE, 17'd60000);
    send(FUNC_UPDATE, 4'd0, 16'd0, 32'd7400, SYS_IDLE, 17'd60000);
    // tick wraps through zero
    send(FUNC_UPDATE, 4'd0, 16'd0, 32'hFFFF_FFF0, SYS_FAULT, 17'd60000);
    send(FUNC_UPDATE, 4'd0, 16'd0, 32'd120, SYS_FAULT, 17'd60000);
    send(FUNC_CELL_WRITE, 4'd0, 16'd3300, 32'd0, SYS_IDLE, 17'd0);
    send(FUNC_CELL_WRITE, 4'd14, 16'd3350, 32'd0, SYS_IDLE, 17'd0);
    send(FUNC_UPDATE, 4'd0, 16'd0, 32'd300, SYS_DISCHARGE, 17'd131071);

    clock_ms = 32'hFFFF_F000;
    random_items(280);

    // mid-range settings, with a long stretch of no idling in the middle
    apply_config(16'($urandom_range(3000)), 16'($urandom_range(3000)),
                 16'($urandom_range(4000)), 16'($urandom_range(500)),
                 16'($urandom_range(1000)), 16'($urandom_range(2000)),
                 17'($urandom_range(80000, 20000)), 16'($urandom_range(65535, 3000)));
    random_items(100);
    calm = 1'b1;
    random_items(150);
    calm = 1'b0;
    random_items(80);

    // all zero: every timer fires on every update, ceiling pulls minimum down
    apply_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 17'd0, 16'd0);
    random_items(300);

    // all at maximum: balancing can never hold
    apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 17'h1FFFF, 16'hFFFF);
    random_items(300);

    // short periods and moderate thresholds
    apply_config(16'($urandom_range(200)), 16'($urandom_range(200)),
                 16'($urandom_range(200)), 16'($urandom_range(200)),
                 16'($urandom_range(200)), 16'($urandom_range(1500)),
                 17'($urandom_range(60000)), 16'($urandom_range(6000)));
    random_items(370);

    settle();
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hard stop in case the handshakes hang
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/bsls_pkg.sv
hw/rtl/battery_status_led_sequencer.sv
test/led_report_checker.sv
test/tb_top.sv
